// ===== sv/hbbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc_pkg
// Shared types, codes and default sizes of the hashed block buffer cache.
// ----------------------------------------------------------------------------
package hbbc_pkg;

	// default pool sizes
	localparam int DEF_NUM_BUFFERS = 32;
	localparam int DEF_NUM_BUCKETS = 13;

	// field widths
	localparam int ACT_W   = 2;
	localparam int DEV_W   = 8;
	localparam int BLK_W   = 32;
	localparam int IDX_W   = 5;
	localparam int ST_W    = 3;
	localparam int CNT_W   = 8;
	// key sum is formed one bit wider than the block number
	localparam int HASH_BITS = BLK_W + 1;
	// buffer descriptor word: device key, block key, reference count
	localparam int BUF_W   = DEV_W + BLK_W + CNT_W;

	typedef logic [ACT_W-1:0] action_t;
	typedef logic [ST_W-1:0]  status_t;

	// actions
	localparam action_t ACT_GET     = 2'd0;
	localparam action_t ACT_RELEASE = 2'd1;
	localparam action_t ACT_PIN     = 2'd2;
	localparam action_t ACT_UNPIN   = 2'd3;

	// result status
	localparam status_t ST_VALID     = 3'd0;
	localparam status_t ST_FILL      = 3'd1;
	localparam status_t ST_NOFREE    = 3'd2;
	localparam status_t ST_UNDERFLOW = 3'd3;
	localparam status_t ST_OK        = 3'd4;

	localparam logic [CNT_W-1:0] REF_MAX = 8'hFF;

endpackage

// ===== sv/hbbc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc_req_if / hbbc_rsp_if
// Valid/ready channels carrying cache requests and their results.
// ----------------------------------------------------------------------------
interface hbbc_req_if import hbbc_pkg::*; ();
	logic               valid;
	logic               ready;
	action_t            action;
	logic [DEV_W-1:0]   dev;
	logic [BLK_W-1:0]   block_number;
	logic [IDX_W-1:0]   buffer_index;

	modport source(output valid, action, dev, block_number, buffer_index, input ready);
	modport sink(input valid, action, dev, block_number, buffer_index, output ready);
endinterface

interface hbbc_rsp_if import hbbc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   result_buffer;
	status_t            status;
	logic [CNT_W-1:0]   ref_count;

	modport source(output valid, result_buffer, status, ref_count, input ready);
	modport sink(input valid, result_buffer, status, ref_count, output ready);
endinterface

// ===== sv/hashed_block_buffer_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// Buffer pool on per-bucket doubly linked lists with lookup and reference
// counting, run by a small sequencer over shared link and descriptor RAMs.
// ----------------------------------------------------------------------------
// usage
//   req: valid/ready request channel (action, dev, block_number,
//   buffer_index). ready is high only while the sequencer is idle.
//   rsp: valid/ready result channel (result_buffer, status, ref_count), one
//   result per request, held in an output register until taken.
// sequence
//   release, pin, unpin: the descriptor is read, updated and written back,
//   then the result is loaded (an out-of-range index goes straight to the
//   result). get: the remainder unit works through the key sum a byte at a
//   time, then the forward walk of the bucket visits each node including its
//   head, the backward free-buffer scans visit one node at a time, link
//   writes follow when a buffer moves bucket, and the result is loaded.
// reset
//   valid bits over the link and descriptor RAMs clear at once, so the
//   pool reads as all buffers in bucket zero; requests are taken
//   straight after reset with no clearing pass.
// stall
//   a request may be accepted while a result waits; its own result waits
//   in the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache import hbbc_pkg::*; #(
	parameter int NUM_BUFFERS = DEF_NUM_BUFFERS,
	parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
	input  logic        clk,
	input  logic        arst_n,
	hbbc_req_if.sink    req,
	hbbc_rsp_if.source  rsp
);

	localparam int NODES = NUM_BUFFERS + NUM_BUCKETS;
	localparam int NW    = $clog2(NODES);
	localparam int BW    = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int KW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int CW    = KW + 1;
	localparam logic [NW-1:0] HEAD0 = NW'(NUM_BUFFERS);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HASH  = 4'd1;
	localparam logic [3:0] S_FWD   = 4'd2;
	localparam logic [3:0] S_BWD   = 4'd3;
	localparam logic [3:0] S_RMW   = 4'd4;
	localparam logic [3:0] S_LINK1 = 4'd5;
	localparam logic [3:0] S_LINK2 = 4'd6;
	localparam logic [3:0] S_LINK3 = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q, state_d;

	// request fields
	action_t          act_q, act_d;
	logic [DEV_W-1:0] dev_q, dev_d;
	logic [BLK_W-1:0] blk_q, blk_d;

	// walk registers
	logic [NW-1:0] p_q, p_d;
	logic [NW-1:0] head_q, head_d;
	logic [NW-1:0] first_q, first_d;
	logic [NW-1:0] scan_head_q, scan_head_d;
	logic [KW-1:0] bk_q, bk_d;
	logic [KW-1:0] scan_i_q, scan_i_d;
	logic          own_q, own_d;
	logic [NW-1:0] pick_q, pick_d;
	logic [NW-1:0] pnx_q, pnx_d;
	logic [NW-1:0] ppv_q, ppv_d;

	// pending and output result
	logic [IDX_W-1:0] pnd_buf_q, pnd_buf_d;
	status_t          pnd_st_q, pnd_st_d;
	logic [CNT_W-1:0] pnd_cnt_q, pnd_cnt_d;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_buf_q;
	status_t          out_st_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_load;

	// valid bits over the RAMs
	logic [NODES-1:0]       nv_q, pv_q;
	logic [NUM_BUFFERS-1:0] bv_q, cv_q;

	// ram ports
	logic [NW-1:0]    rd_addr;
	logic [NW-1:0]    rd_node_q;
	logic             nx_we, pr_we, bf_we;
	logic [NW-1:0]    nx_waddr, nx_wdata, pr_waddr, pr_wdata;
	logic [BW-1:0]    bf_waddr;
	logic [BUF_W-1:0] bf_wdata;
	logic             cv_set;
	logic [NW-1:0]    nx_raw, pr_raw;
	logic [BUF_W-1:0] bf_raw;

	// read side after valid masking
	logic [NW-1:0]    next_rd, prev_rd;
	logic [BW-1:0]    rd_bidx;
	logic [BUF_W-1:0] bf_rd;
	logic [DEV_W-1:0] rd_kd;
	logic [BLK_W-1:0] rd_kb;
	logic [CNT_W-1:0] rd_rc;
	logic             rd_cv;
	logic [CNT_W-1:0] rc_inc;

	// hash unit
	logic             hash_start;
	logic             hash_done;
	logic [KW-1:0]    hash_bucket;

	// next bucket to scan
	logic [CW-1:0]    c0, c1;
	logic             scan_exhausted;

	// reset image of the link lists: all buffers in bucket zero, newest last
	function automatic logic [NW-1:0] next_init(input logic [NW-1:0] n);
		if (n == HEAD0) begin
			return NW'(NUM_BUFFERS - 1);
		end else if (n > HEAD0) begin
			return n;
		end else if (n == '0) begin
			return HEAD0;
		end else begin
			return n - NW'(1);
		end
	endfunction

	function automatic logic [NW-1:0] prev_init(input logic [NW-1:0] n);
		if (n == HEAD0) begin
			return '0;
		end else if (n > HEAD0) begin
			return n;
		end else if (n == NW'(NUM_BUFFERS - 1)) begin
			return HEAD0;
		end else begin
			return n + NW'(1);
		end
	endfunction

	hbbc_hash #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.sum    (HASH_BITS'(req.dev) + HASH_BITS'(req.block_number)),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	hbbc_ram #(
		.WIDTH(NW),
		.DEPTH(NODES)
	) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (rd_addr),
		.rdata (nx_raw)
	);

	hbbc_ram #(
		.WIDTH(NW),
		.DEPTH(NODES)
	) u_prev_ram (
		.clk   (clk),
		.we    (pr_we),
		.waddr (pr_waddr),
		.wdata (pr_wdata),
		.raddr (rd_addr),
		.rdata (pr_raw)
	);

	hbbc_ram #(
		.WIDTH(BUF_W),
		.DEPTH(NUM_BUFFERS)
	) u_buf_ram (
		.clk   (clk),
		.we    (bf_we),
		.waddr (bf_waddr),
		.wdata (bf_wdata),
		.raddr (rd_addr[BW-1:0]),
		.rdata (bf_raw)
	);

	// read data, unwritten entries show their reset value
	always_comb begin
		rd_bidx = rd_node_q[BW-1:0];
		next_rd = nv_q[rd_node_q] ? nx_raw : next_init(rd_node_q);
		prev_rd = pv_q[rd_node_q] ? pr_raw : prev_init(rd_node_q);
		bf_rd   = bv_q[rd_bidx] ? bf_raw : '0;
		rd_cv   = cv_q[rd_bidx];
		{rd_kd, rd_kb, rd_rc} = bf_rd;
		rc_inc  = (rd_rc == REF_MAX) ? rd_rc : rd_rc + CNT_W'(1);
	end

	// bucket order for the free scan: own bucket, then others by index
	always_comb begin
		c0 = own_q ? '0 : CW'(scan_i_q) + CW'(1);
		c1 = (c0 == CW'(bk_q)) ? c0 + CW'(1) : c0;
		scan_exhausted = (c1 >= CW'(NUM_BUCKETS));
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		act_d       = act_q;
		dev_d       = dev_q;
		blk_d       = blk_q;
		p_d         = p_q;
		head_d      = head_q;
		first_d     = first_q;
		scan_head_d = scan_head_q;
		bk_d        = bk_q;
		scan_i_d    = scan_i_q;
		own_d       = own_q;
		pick_d      = pick_q;
		pnx_d       = pnx_q;
		ppv_d       = ppv_q;
		pnd_buf_d   = pnd_buf_q;
		pnd_st_d    = pnd_st_q;
		pnd_cnt_d   = pnd_cnt_q;
		rd_addr     = p_q;
		hash_start  = 1'b0;
		nx_we       = 1'b0;
		nx_waddr    = '0;
		nx_wdata    = '0;
		pr_we       = 1'b0;
		pr_waddr    = '0;
		pr_wdata    = '0;
		bf_we       = 1'b0;
		bf_waddr    = '0;
		bf_wdata    = '0;
		cv_set      = 1'b0;
		out_load    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					act_d = req.action;
					dev_d = req.dev;
					blk_d = req.block_number;
					if (req.action == ACT_GET) begin
						hash_start = 1'b1;
						state_d    = S_HASH;
					end else if (int'(req.buffer_index) < NUM_BUFFERS) begin
						rd_addr = NW'(req.buffer_index);
						p_d     = NW'(req.buffer_index);
						state_d = S_RMW;
					end else begin
						pnd_buf_d = req.buffer_index;
						pnd_st_d  = ST_OK;
						pnd_cnt_d = '0;
						state_d   = S_DONE;
					end
				end
			end

			S_HASH: begin
				if (hash_done) begin
					bk_d    = hash_bucket;
					head_d  = HEAD0 + NW'(hash_bucket);
					rd_addr = HEAD0 + NW'(hash_bucket);
					p_d     = HEAD0 + NW'(hash_bucket);
					state_d = S_FWD;
				end
			end

			// lookup from the newest entry
			S_FWD: begin
				if (p_q != head_q && rd_kd == dev_q && rd_kb == blk_q) begin
					bf_we     = 1'b1;
					bf_waddr  = p_q[BW-1:0];
					bf_wdata  = {rd_kd, rd_kb, rc_inc};
					cv_set    = 1'b1;
					pnd_buf_d = IDX_W'(p_q);
					pnd_st_d  = rd_cv ? ST_VALID : ST_FILL;
					pnd_cnt_d = rc_inc;
					state_d   = S_DONE;
				end else begin
					if (p_q == head_q) begin
						first_d = next_rd;
					end
					if (next_rd == head_q) begin
						rd_addr     = head_q;
						p_d         = head_q;
						scan_head_d = head_q;
						own_d       = 1'b1;
						state_d     = S_BWD;
					end else begin
						rd_addr = next_rd;
						p_d     = next_rd;
					end
				end
			end

			// free buffer scan from the oldest entry
			S_BWD: begin
				if (p_q != scan_head_q && rd_rc == '0) begin
					pick_d    = p_q;
					pnx_d     = next_rd;
					ppv_d     = prev_rd;
					bf_we     = 1'b1;
					bf_waddr  = p_q[BW-1:0];
					bf_wdata  = {dev_q, blk_q, CNT_W'(1)};
					cv_set    = 1'b1;
					pnd_buf_d = IDX_W'(p_q);
					pnd_st_d  = ST_FILL;
					pnd_cnt_d = CNT_W'(1);
					state_d   = own_q ? S_DONE : S_LINK1;
				end else if (prev_rd != scan_head_q) begin
					rd_addr = prev_rd;
					p_d     = prev_rd;
				end else if (scan_exhausted) begin
					pnd_buf_d = '0;
					pnd_st_d  = ST_NOFREE;
					pnd_cnt_d = '0;
					state_d   = S_DONE;
				end else begin
					scan_i_d    = KW'(c1);
					own_d       = 1'b0;
					rd_addr     = HEAD0 + NW'(c1);
					p_d         = HEAD0 + NW'(c1);
					scan_head_d = HEAD0 + NW'(c1);
				end
			end

			// release, pin, unpin
			S_RMW: begin
				pnd_buf_d = IDX_W'(p_q);
				pnd_st_d  = ST_OK;
				if (act_q == ACT_PIN) begin
					pnd_cnt_d = rc_inc;
				end else if (rd_rc == '0) begin
					pnd_cnt_d = '0;
					pnd_st_d  = ST_UNDERFLOW;
				end else begin
					pnd_cnt_d = rd_rc - CNT_W'(1);
				end
				bf_we    = 1'b1;
				bf_waddr = p_q[BW-1:0];
				bf_wdata = {rd_kd, rd_kb, pnd_cnt_d};
				state_d  = S_DONE;
			end

			// unlink from the old bucket
			S_LINK1: begin
				nx_we    = 1'b1;
				nx_waddr = ppv_q;
				nx_wdata = pnx_q;
				pr_we    = 1'b1;
				pr_waddr = pnx_q;
				pr_wdata = ppv_q;
				state_d  = S_LINK2;
			end

			// point the picked buffer into the target bucket
			S_LINK2: begin
				nx_we    = 1'b1;
				nx_waddr = pick_q;
				nx_wdata = first_q;
				pr_we    = 1'b1;
				pr_waddr = pick_q;
				pr_wdata = head_q;
				state_d  = S_LINK3;
			end

			// hook it in at the head
			S_LINK3: begin
				nx_we    = 1'b1;
				nx_waddr = head_q;
				nx_wdata = pick_q;
				pr_we    = 1'b1;
				pr_waddr = first_q;
				pr_wdata = pick_q;
				state_d  = S_DONE;
			end

			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			nv_q        <= '0;
			pv_q        <= '0;
			bv_q        <= '0;
			cv_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (nx_we) begin
				nv_q[nx_waddr] <= 1'b1;
			end
			if (pr_we) begin
				pv_q[pr_waddr] <= 1'b1;
			end
			if (bf_we) begin
				bv_q[bf_waddr] <= 1'b1;
			end
			if (cv_set) begin
				cv_q[bf_waddr] <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		act_q       <= act_d;
		dev_q       <= dev_d;
		blk_q       <= blk_d;
		p_q         <= p_d;
		head_q      <= head_d;
		first_q     <= first_d;
		scan_head_q <= scan_head_d;
		bk_q        <= bk_d;
		scan_i_q    <= scan_i_d;
		own_q       <= own_d;
		pick_q      <= pick_d;
		pnx_q       <= pnx_d;
		ppv_q       <= ppv_d;
		pnd_buf_q   <= pnd_buf_d;
		pnd_st_q    <= pnd_st_d;
		pnd_cnt_q   <= pnd_cnt_d;
		rd_node_q   <= rd_addr;
		if (out_load) begin
			out_buf_q <= pnd_buf_q;
			out_st_q  <= pnd_st_q;
			out_cnt_q <= pnd_cnt_q;
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.result_buffer = out_buf_q;
	assign rsp.status        = out_st_q;
	assign rsp.ref_count     = out_cnt_q;

`ifndef ASSERT_OFF
	// the sequencer closes after each accepted request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while sequencer busy");

	// a buffer moved across buckets never lands on its own new neighbour
	a_pick_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK2 |-> pick_q != first_q && pick_q != head_q)
		else $error("picked buffer aliases target bucket links");

	// the remainder unit reports only while a get waits for it
	a_hash_owner: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == S_HASH)
		else $error("bucket result outside hash wait");

	// an exhausted pool reports no buffer and no count
	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && pnd_st_q == ST_NOFREE |=> out_buf_q == '0 && out_cnt_q == '0)
		else $error("no free buffer result carries data");
`endif

endmodule

// ===== sv/hbbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hbbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/hbbc_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc_hash
// Remainder unit: bucket = key sum mod NUM_BUCKETS, one byte a cycle.
// ----------------------------------------------------------------------------
module hbbc_hash import hbbc_pkg::*; #(
	parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               start,
	input  logic [HASH_BITS-1:0]                               sum,
	output logic                                               done,
	output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);

	localparam int KW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int NCH  = (HASH_BITS + 7) / 8;
	localparam int SHW  = NCH * 8;
	localparam int CNTW = $clog2(NCH + 1);

	logic [SHW-1:0]  sh_q;
	logic [KW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [KW-1:0]   rtab [2**KW];
	logic [KW-1:0]   btab [256];
	logic [KW:0]     rem_ext;
	logic [KW-1:0]   rem_nx;

	// remainder of r * 256 for every partial remainder r
	for (genvar g = 0; g < 2**KW; g++) begin : g_rtab
		assign rtab[g] = KW'((g * 256) % NUM_BUCKETS);
	end

	// remainder of every byte value
	for (genvar g = 0; g < 256; g++) begin : g_btab
		assign btab[g] = KW'(g % NUM_BUCKETS);
	end

	// fold in the next byte and bring back below the divisor
	always_comb begin
		rem_ext = {1'b0, rtab[rem_q]} + {1'b0, btab[sh_q[SHW-1 -: 8]]};
		if (rem_ext >= (KW + 1)'(NUM_BUCKETS)) begin
			rem_nx = KW'(rem_ext - (KW + 1)'(NUM_BUCKETS));
		end else begin
			rem_nx = KW'(rem_ext);
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NCH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= SHW'(sum);
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[SHW-9:0], 8'h00};
			rem_q <= rem_nx;
		end
	end

	assign done   = done_q;
	assign bucket = rem_q;

endmodule
